// ===== hw/rtl/nhmm_pkg.sv =====
// ----------------------------------------------------------------------------
// Name hash package
// Shared constants, state types and control structs for the file name
// hashing block and its mixing unit.
// ----------------------------------------------------------------------------
package nhmm_pkg;

    // Default limit on the number of name bytes that are hashed.
    localparam int NHMM_MAX_NAME_BYTES = 256;

    // Initial values of the mixing state.
    localparam logic [31:0] NHMM_KEY_INIT   = 32'hF4FA8928;
    localparam logic [31:0] NHMM_X_INIT     = 32'h37A8470E;
    localparam logic [31:0] NHMM_Y_INIT     = 32'h7758B42B;

    // Fixed words mixed at the end of every name.
    localparam logic [31:0] NHMM_TAIL_WORD0 = 32'h9BE74448;
    localparam logic [31:0] NHMM_TAIL_WORD1 = 32'h66F42C48;

    // Round constants.
    localparam logic [31:0] NHMM_ROUND_W    = 32'h267B0B11;
    localparam logic [31:0] NHMM_OR_A       = 32'h02040801;
    localparam logic [31:0] NHMM_AND_C      = 32'hBFEF7FDF;
    localparam logic [31:0] NHMM_OR_B       = 32'h00804021;
    localparam logic [31:0] NHMM_AND_D      = 32'h7DFEFBFF;

    // Character codes used by the normalization.
    localparam logic [7:0]  NHMM_CHAR_UPPER_A = 8'h41;
    localparam logic [7:0]  NHMM_CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0]  NHMM_CHAR_BSLASH  = 8'h5C;
    localparam logic [7:0]  NHMM_CHAR_SLASH   = 8'h2F;
    localparam logic [7:0]  NHMM_CASE_OFFSET  = 8'h20;

    // Top level sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_TAIL0,
        ST_TAIL1,
        ST_FIN
    } nhmm_state_t;

    // Mixing unit states.
    typedef enum logic [1:0] {
        MX_IDLE,
        MX_MULX,
        MX_MULY,
        MX_FINY
    } nhmm_mix_state_t;

    // Commands from the sequencer to the mixing unit.
    typedef struct packed {
        logic start;
        logic clear;
    } nhmm_mix_ctrl_t;

endpackage

// ===== hw/rtl/nhmm_mul.sv =====
// ----------------------------------------------------------------------------
// Name hash multiplier
// Registered 32x32 unsigned multiplier shared by both products of a round.
// ----------------------------------------------------------------------------
module nhmm_mul import nhmm_pkg::*; (
    input  logic        aclk,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    always_ff @(posedge aclk) begin
        product_reg <= {32'b0, op_a} * {32'b0, op_b};
    end

    assign product = product_reg;

endmodule

// ===== hw/rtl/nhmm_mix.sv =====
// ----------------------------------------------------------------------------
// Name hash mixing unit
// Holds the accumulators and rotating key and runs one mixing round per
// start command, using the shared multiplier for both products.
// ----------------------------------------------------------------------------
module nhmm_mix import nhmm_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  nhmm_mix_ctrl_t ctrl,
    input  logic [31:0]    word,
    output logic           busy,
    output logic [31:0]    hash
);

    nhmm_mix_state_t state_reg, state_next;
    logic [31:0] acc_x_reg, acc_x_next;
    logic [31:0] acc_y_reg, acc_y_next;
    logic [31:0] rot_key_reg, rot_key_next;
    logic [31:0] mx_reg, mx_next;
    logic [31:0] my_reg, my_next;

    logic [31:0] key_rot;
    logic [31:0] k;
    logic [31:0] x_in;
    logic [31:0] y_in;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] product;
    logic [32:0] sum_x;
    logic [32:0] sum_y;
    logic [31:0] fold_x;
    logic [31:0] fold_y;

    nhmm_mul u_mul (
        .aclk    (aclk),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= MX_IDLE;
            acc_x_reg   <= NHMM_X_INIT;
            acc_y_reg   <= NHMM_Y_INIT;
            rot_key_reg <= NHMM_KEY_INIT;
        end else begin
            state_reg   <= state_next;
            acc_x_reg   <= acc_x_next;
            acc_y_reg   <= acc_y_next;
            rot_key_reg <= rot_key_next;
        end
        mx_reg <= mx_next;
        my_reg <= my_next;
    end

    // Round setup, end-around-carry fold for x and doubled-high fold for y.
    always_comb begin
        key_rot = {rot_key_reg[30:0], rot_key_reg[31]};
        k       = NHMM_ROUND_W ^ key_rot;
        x_in    = acc_x_reg ^ word;
        y_in    = acc_y_reg ^ word;
        sum_x   = {1'b0, product[31:0]} + {1'b0, product[63:32]};
        fold_x  = sum_x[31:0] + {31'b0, sum_x[32]};
        sum_y   = {1'b0, product[31:0]} + {1'b0, product[62:32], 1'b0};
        fold_y  = sum_y[31:0] + {30'b0, sum_y[32], 1'b0};
    end

    always_comb begin
        state_next   = state_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        rot_key_next = rot_key_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        mul_a        = acc_x_reg;
        mul_b        = mx_reg;
        case (state_reg)
            MX_IDLE: begin
                if (ctrl.clear) begin
                    acc_x_next   = NHMM_X_INIT;
                    acc_y_next   = NHMM_Y_INIT;
                    rot_key_next = NHMM_KEY_INIT;
                end else if (ctrl.start) begin
                    rot_key_next = key_rot;
                    acc_x_next   = x_in;
                    acc_y_next   = y_in;
                    mx_next      = ((k + y_in) | NHMM_OR_A) & NHMM_AND_C;
                    my_next      = ((k + x_in) | NHMM_OR_B) & NHMM_AND_D;
                    state_next   = MX_MULX;
                end
            end
            MX_MULX: begin
                mul_a      = acc_x_reg;
                mul_b      = mx_reg;
                state_next = MX_MULY;
            end
            MX_MULY: begin
                mul_a      = acc_y_reg;
                mul_b      = my_reg;
                acc_x_next = fold_x;
                state_next = MX_FINY;
            end
            MX_FINY: begin
                acc_y_next = fold_y;
                state_next = MX_IDLE;
            end
            default: begin
                state_next = MX_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != MX_IDLE);
    assign hash = acc_x_reg ^ acc_y_reg;

endmodule

// ===== hw/rtl/name_hash_mul_mix.sv =====
// ----------------------------------------------------------------------------
// File name hash with multiply mixing
// A byte that does not complete a word is taken without a round; a byte that
// completes a word starts a mixing round and holds the input until it ends.
// After the last byte, up to three rounds (padding word, two fixed words)
// run, and the hash is registered once they end and the output is free.
// The shared 32x32 multiplier, used twice per round, sets the round length.
// Reset (aresetn, synchronous, active low) clears all name state and sets
// normalize_mode to 1.
// ----------------------------------------------------------------------------
module name_hash_mul_mix import nhmm_pkg::*; #(
    parameter int MAX_NAME_BYTES = NHMM_MAX_NAME_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration: normalize_mode
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    // Input channel: one name byte per transaction
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_name_byte,
    input  logic        s_last,
    // Result channel: one hash per name
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash_value
);

    // The byte counter must hold the limit itself.
    localparam int CW = $clog2(MAX_NAME_BYTES + 1);
    localparam logic [CW-1:0] ByteLimit = CW'(MAX_NAME_BYTES);
    localparam logic [CW-3:0] WordLimit = (CW-2)'(MAX_NAME_BYTES / 4);

    nhmm_state_t    state_reg, state_next;
    logic           normalize_mode_reg;
    logic [31:0]    word_buffer_reg, word_buffer_next;
    logic [1:0]     byte_lane_reg, byte_lane_next;
    logic [CW-1:0]  byte_count_reg, byte_count_next;
    logic           m_valid_reg, m_valid_next;
    logic [31:0]    m_hash_value_reg, m_hash_value_next;

    nhmm_mix_ctrl_t mix_ctrl;
    logic [31:0]    mix_word;
    logic           mix_busy;
    logic [31:0]    mix_hash;

    logic           accept;
    logic [7:0]     norm_byte;
    logic [31:0]    packed_word;
    logic           pad_needed;

    // The mixing unit owns the accumulators and the rotating key.
    nhmm_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mix_ctrl),
        .word    (mix_word),
        .busy    (mix_busy),
        .hash    (mix_hash)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            normalize_mode_reg <= 1'b1;
            word_buffer_reg    <= '0;
            byte_lane_reg      <= '0;
            byte_count_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            word_buffer_reg <= word_buffer_next;
            byte_lane_reg   <= byte_lane_next;
            byte_count_reg  <= byte_count_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we) begin
                normalize_mode_reg <= cfg_wdata;
            end
        end
        m_hash_value_reg <= m_hash_value_next;
    end

    // A new byte is taken only while the mixing unit is free, since the
    // byte may complete a word that starts a round at once.
    assign s_ready = (state_reg == ST_IDLE) && !mix_busy;
    assign accept  = s_valid && s_ready;

    // Optional folding of upper case to lower case and backslash to slash.
    always_comb begin
        norm_byte = s_name_byte;
        if (normalize_mode_reg) begin
            if (s_name_byte >= NHMM_CHAR_UPPER_A && s_name_byte <= NHMM_CHAR_UPPER_Z) begin
                norm_byte = s_name_byte + NHMM_CASE_OFFSET;
            end else if (s_name_byte == NHMM_CHAR_BSLASH) begin
                norm_byte = NHMM_CHAR_SLASH;
            end
        end
        packed_word = word_buffer_reg | ({24'b0, norm_byte} << {byte_lane_reg, 3'b000});
    end

    // A partial word is padded and mixed only while the word limit allows it.
    assign pad_needed = (byte_lane_reg != 2'd0) && (byte_count_reg[CW-1:2] < WordLimit);

    always_comb begin
        state_next        = state_reg;
        word_buffer_next  = word_buffer_reg;
        byte_lane_next    = byte_lane_reg;
        byte_count_next   = byte_count_reg;
        m_valid_next      = m_valid_reg;
        m_hash_value_next = m_hash_value_reg;
        mix_ctrl          = '0;
        mix_word          = word_buffer_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    // Bytes past the limit are dropped, but last still ends the name.
                    if (byte_count_reg < ByteLimit) begin
                        byte_count_next = byte_count_reg + 1'b1;
                        byte_lane_next  = byte_lane_reg + 1'b1;
                        if (byte_lane_reg == 2'd3) begin
                            mix_word         = packed_word;
                            mix_ctrl.start   = 1'b1;
                            word_buffer_next = '0;
                        end else begin
                            word_buffer_next = packed_word;
                        end
                    end
                    if (s_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (!mix_busy) begin
                    mix_ctrl.start = pad_needed;
                    state_next     = ST_TAIL0;
                end
            end
            ST_TAIL0: begin
                if (!mix_busy) begin
                    mix_word       = NHMM_TAIL_WORD0;
                    mix_ctrl.start = 1'b1;
                    state_next     = ST_TAIL1;
                end
            end
            ST_TAIL1: begin
                if (!mix_busy) begin
                    mix_word       = NHMM_TAIL_WORD1;
                    mix_ctrl.start = 1'b1;
                    state_next     = ST_FIN;
                end
            end
            ST_FIN: begin
                // The result waits here until the last round ends and the output
                // register no longer holds an untaken hash of the previous name.
                if (!mix_busy && (!m_valid_reg || m_ready)) begin
                    m_valid_next      = 1'b1;
                    m_hash_value_next = mix_hash;
                    mix_ctrl.clear    = 1'b1;
                    word_buffer_next  = '0;
                    byte_lane_next    = '0;
                    byte_count_next   = '0;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_hash_value = m_hash_value_reg;

endmodule

// ===== dv/tb_name_hash_mul_mix.sv =====
// ----------------------------------------------------------------------------
// Testbench for the file name hash block
// Streams file names one byte per transaction into name_hash_mul_mix and
// checks every hash against a cycle-free model of the mixing rounds that runs
// alongside. Covers case folding on and off, short and padded final words,
// embedded zero bytes, truncation of long names and random traffic with
// random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_name_hash_mul_mix;
    import nhmm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Largest number of cycles in which no transaction and no register
    // write may happen before the run is declared hung. A name byte costs at
    // most a random input gap plus a mixing round, and a hash at most three
    // rounds plus a hash channel stall, so this leaves a wide margin.
    localparam int QUIET_LIMIT  = 2000;
    // Cycles allowed for the block to settle once no hash is outstanding.
    localparam int SETTLE_LIMIT = 30;
    localparam int NAME_LIMIT   = NHMM_MAX_NAME_BYTES;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_name_byte;
    logic        s_last;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_hash_value;

    // Model state for the name being hashed. It mirrors the block's packing
    // and mixing state and is cleared after every hash.
    logic        name_mode;
    logic [31:0] pack_word;
    logic [1:0]  pack_lane;
    int          pack_count;
    int          words_mixed;
    logic [31:0] mix_x;
    logic [31:0] mix_y;
    logic [31:0] mix_key;

    // Hashes predicted but not yet delivered by the block, oldest first.
    logic [31:0] pending_hashes[$];
    logic [31:0] wanted_hash;

    int fails      = 0;
    int quiet_run  = 0;
    int stall_left = 0;
    bit idle_on    = 1'b1;

    always #5ns aclk = ~aclk;

    name_hash_mul_mix DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_name_byte (s_name_byte),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hash_value(m_hash_value)
    );

    // ------------------------------------------------------------------------
    // Hash model
    // ------------------------------------------------------------------------

    // Brings the per-name state back to its starting values. The
    // normalization setting is a register and survives this.
    function automatic void clear_name();
        pack_word   = '0;
        pack_lane   = '0;
        pack_count  = 0;
        words_mixed = 0;
        mix_x       = NHMM_X_INIT;
        mix_y       = NHMM_Y_INIT;
        mix_key     = NHMM_KEY_INIT;
    endfunction

    // One mixing round. The key turns left by one bit first. The x product
    // is folded with an end-around carry of one, while the y product has its
    // high half doubled and folds back a carry of two. Note that the y
    // multiplier is formed from x before x takes its new value.
    function automatic void mix_round(input logic [31:0] w);
        logic [31:0] k;
        logic [31:0] mx;
        logic [31:0] my;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] t;
        logic [63:0] p;
        mix_key = {mix_key[30:0], mix_key[31]};
        k       = NHMM_ROUND_W ^ mix_key;
        mix_x   = mix_x ^ w;
        mix_y   = mix_y ^ w;

        mx = ((k + mix_y) | NHMM_OR_A) & NHMM_AND_C;
        p  = {32'd0, mix_x} * {32'd0, mx};
        lo = p[31:0];
        hi = p[63:32];
        t  = lo + hi;
        if (t < hi) begin
            t = t + 32'd1;
        end
        my    = ((k + mix_x) | NHMM_OR_B) & NHMM_AND_D;
        mix_x = t;

        p  = {32'd0, mix_y} * {32'd0, my};
        lo = p[31:0];
        hi = p[63:32];
        hi = hi + hi;
        t  = lo + hi;
        if (t < hi) begin
            t = t + 32'd2;
        end
        mix_y = t;
    endfunction

    // Folds one accepted byte into the model. Bytes past the length limit
    // are dropped, but a dropped byte with the last flag still closes the
    // name. A partial final word is zero padded and mixed unless the word
    // limit has been reached; the two fixed words always follow.
    function automatic void absorb_byte(input logic [7:0] b, input logic lst);
        logic [7:0] c;
        c = b;
        if (pack_count < NAME_LIMIT) begin
            if (name_mode) begin
                if (c >= NHMM_CHAR_UPPER_A && c <= NHMM_CHAR_UPPER_Z) begin
                    c = c + NHMM_CASE_OFFSET;
                end else if (c == NHMM_CHAR_BSLASH) begin
                    c = NHMM_CHAR_SLASH;
                end
            end
            pack_word  = pack_word | ({24'd0, c} << (8 * pack_lane));
            pack_count = pack_count + 1;
            pack_lane  = pack_lane + 2'd1;
            if (pack_lane == 2'd0) begin
                mix_round(pack_word);
                words_mixed = words_mixed + 1;
                pack_word   = '0;
            end
        end
        if (lst) begin
            if (pack_lane != 2'd0 && words_mixed < NAME_LIMIT / 4) begin
                mix_round(pack_word);
            end
            mix_round(NHMM_TAIL_WORD0);
            mix_round(NHMM_TAIL_WORD1);
            pending_hashes.push_back(mix_x ^ mix_y);
            clear_name();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and checking
    // ------------------------------------------------------------------------

    // The hash channel stalls in bursts of random length while idling is
    // enabled and is always ready in the final stretch of the run.
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every hash transaction is matched against the oldest prediction. Values
    // are sampled at the edge, before the block updates its outputs.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: unexpected hash: expected none, actual %08h",
                         $time, m_hash_value);
                fails++;
            end else begin
                wanted_hash = pending_hashes.pop_front();
                if (m_hash_value !== wanted_hash) begin
                    $display("%0t: hash mismatch: expected %08h, actual %08h",
                             $time, wanted_hash, m_hash_value);
                    fails++;
                end
            end
        end
    end

    // Hang detector: counts cycles without any transaction or register write.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_run <= 0;
        end else if (quiet_run >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_run);
            $display("name_hash_mul_mix regression: fail");
            $finish;
        end else begin
            quiet_run <= quiet_run + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Presents one name byte and holds it until the block takes it. Every
    // call starts and ends on a rising edge. Valid is only dropped when a gap
    // is inserted, so a back-to-back byte never sees valid lowered and raised
    // in the same step.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_name_byte <= b;
        s_last      <= lst;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        absorb_byte(b, lst);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i], i == text.len() - 1);
        end
    endtask

    // Characters are skewed toward upper case letters and backslash so that
    // the normalization paths are hit often.
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return 8'($urandom_range(NHMM_CHAR_UPPER_A, NHMM_CHAR_UPPER_Z));
        end else if (r == 4) begin
            return NHMM_CHAR_BSLASH;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_random_name(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(pick_char(), i == len - 1);
        end
    endtask

    // The register is only written with the block idle: input valid is
    // dropped, every outstanding hash must have been delivered, and then the
    // block is given time to finish any round still in flight.
    task automatic write_mode(input logic mode);
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_LIMIT) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        name_mode = mode;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Short names with normalization on (its reset value): case folding at
    // the edges of the letter range, backslash, neighbours that must not be
    // folded, the largest byte and the byte 01, a name that fills whole words
    // so no padding round runs, and a zero byte in the middle of a name.
    task automatic test_folding_and_padding();
        send_text("A");
        send_text("Z\\");
        send_text("@[`{");
        send_byte(8'hFF, 1'b1);
        send_byte(8'h01, 1'b1);
        send_text("ab\\Cd");
        send_byte(NHMM_CHAR_UPPER_A, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(NHMM_CHAR_BSLASH, 1'b1);
    endtask

    // Same kind of names with normalization off, then back on.
    task automatic test_raw_mode();
        write_mode(1'b0);
        send_text("A\\z");
        send_byte(8'h80, 1'b1);
        send_text("WXYZ");
        write_mode(1'b1);
    endtask

    // A name one byte over the length limit: it fills the limit exactly and
    // its closing byte is itself dropped.
    task automatic test_long_names();
        send_random_name(NAME_LIMIT + 1);
    endtask

    // Random names, mostly short, with the normalization setting changed
    // every few names. The last stretch runs without idling on either side.
    task automatic test_random_names();
        int sent;
        int names;
        int len;
        sent  = 0;
        names = 0;
        while (sent < 270) begin
            if (sent >= 160) begin
                idle_on = 1'b0;
            end
            if (names % 12 == 11) begin
                write_mode(1'($urandom_range(0, 1)));
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            send_random_name(len);
            sent  += len;
            names += 1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn     <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= 1'b0;
        s_valid     <= 1'b0;
        s_name_byte <= '0;
        s_last      <= 1'b0;
        name_mode = 1'b1;
        clear_name();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_folding_and_padding();
        test_raw_mode();
        test_long_names();
        test_random_names();

        // Drain: wait for every predicted hash, then give the block time to
        // show any result that should not be there.
        s_valid <= 1'b0;
        while (pending_hashes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_LIMIT) @(posedge aclk);

        if (fails == 0) begin
            $display("name_hash_mul_mix regression: pass");
        end else begin
            $display("name_hash_mul_mix regression: fail");
        end
        $finish;
    end

endmodule
